[hw/rtl/dht_pkg.sv]
// Shared constants, slot status and operation codes, and the hash result bundle
// for the double-hashing table. No dependencies.
`default_nettype none

package dht_pkg;

	// Table size is a power of two so the home slot is the low key bits
	localparam int IDX_W      = 4;
	localparam int TABLE_SIZE = 1 << IDX_W;
	localparam int KEY_WIDTH  = 31;

	localparam int SLOT_W = 4;
	localparam int KIND_W = 2;

	// Stream data widths, rounded up to whole bytes
	localparam int IN_DATA_W  = ((KEY_WIDTH + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((SLOT_W + 7) / 8) * 8;

	// Key split into IDX_W-bit digits for the probe step remainder
	localparam int NDIG  = (KEY_WIDTH + IDX_W - 1) / IDX_W;
	localparam int PAD_W = NDIG * IDX_W;
	localparam int SUM_W = 2 * IDX_W;

	localparam int ENTRY_W = 2 + KEY_WIDTH;

	localparam logic [1:0] SLOT_EMPTY   = 2'd0;
	localparam logic [1:0] SLOT_USED    = 2'd1;
	localparam logic [1:0] SLOT_DELETED = 2'd2;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd2;

	typedef struct packed {
		logic             done;
		logic [IDX_W-1:0] home;
		logic [IDX_W-1:0] step;
	} dht_hash_t;

endpackage

`default_nettype wire

[hw/rtl/dht_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire  [$clog2(DEPTH)-1:0]  waddr,
	input  wire  [WIDTH-1:0]          wdata,
	input  wire  [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/dht_hash.sv]
// Hash unit: home slot (key mod TABLE_SIZE, the low key bits) and probe step
// (TABLE_SIZE-1 - key mod (TABLE_SIZE-1), from a sum of key digits). Uses dht_pkg.
`default_nettype none

module dht_hash
	import dht_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire  [KEY_WIDTH-1:0] key,
	output dht_hash_t            res
);

	localparam logic [IDX_W:0] MOD_B = (IDX_W + 1)'(TABLE_SIZE - 1);

	logic             done_q;
	logic [IDX_W-1:0] home_q;
	logic [SUM_W-1:0] sum_q;
	logic [PAD_W-1:0] key_pad;
	logic [SUM_W-1:0] sum_d;
	logic [IDX_W:0]   fold;
	logic [IDX_W:0]   red1;
	logic [IDX_W:0]   red2;

	assign key_pad = PAD_W'(key);

	// Each digit weighs 1 modulo TABLE_SIZE-1, so the digit sum keeps the remainder
	always_comb begin
		sum_d = '0;
		for (int i = 0; i < NDIG; i++) begin
			sum_d = sum_d + SUM_W'(key_pad[i*IDX_W +: IDX_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			home_q <= key[IDX_W-1:0];
			sum_q  <= sum_d;
		end
	end

	// Fold the sum once, then bring it below TABLE_SIZE-1
	assign fold = {1'b0, sum_q[IDX_W-1:0]} + {1'b0, sum_q[SUM_W-1:IDX_W]};
	assign red1 = (fold >= MOD_B) ? fold - MOD_B : fold;
	assign red2 = (red1 >= MOD_B) ? red1 - MOD_B : red1;

	assign res.done = done_q;
	assign res.home = home_q;
	assign res.step = IDX_W'(TABLE_SIZE - 1) - red2[IDX_W-1:0];

endmodule

`default_nettype wire

[hw/rtl/double_hash_table.sv]
// Top level of the double-hashing table: probe sequencer around one slot RAM
// and the hash unit. Uses dht_pkg, dht_hash and dht_ram.
//
// Usage:
//   Slave stream: tuser carries the operation (0 insert, 1 search, 2 erase,
//   3 does nothing), tdata the key. Master stream: tuser carries ok, tdata
//   the slot index; slot is zero when ok is 0.
//   One operation is handled at a time. The input transaction registers the
//   home slot and key digit sum; the hash state then loads the home slot and
//   step, and the probe state walks, reading one slot per cycle from the slot
//   RAM, its data in the cycle after, for up to TABLE_SIZE probes. An unused
//   operation code skips the walk. The next input can go in with the earliest
//   output. The walk through the single RAM read port makes the time vary
//   with the number of probes.
//   Insert and erase write the slot back in the cycle the probe ends.
//   The result sits in an output register; a new input transaction is taken
//   as soon as the sequencer is idle, even while that result waits. If the
//   receiver stalls, the next result is held inside until the register frees.
//   Reset marks every slot empty through per-slot valid flags at once; no
//   clearing pass is needed and the block is ready in the first cycle.
`default_nettype none

module double_hash_table
	import dht_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire  [IN_DATA_W-1:0]  s_axis_tdata,   // [KEY_WIDTH-1:0] key, zero fill above
	input  wire  [KIND_W-1:0]     s_axis_tuser,   // [1:0] kind
	output logic                  m_axis_tvalid,
	input  wire                   m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [3:0] slot, zero fill above
	output logic                  m_axis_tuser    // [0] ok
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_HASH  = 2'd1;
	localparam logic [1:0] S_PROBE = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]            state_q;
	logic [TABLE_SIZE-1:0] valid_q;
	logic [IDX_W-1:0]      ev_q;
	logic                  rv_s1;
	logic [IDX_W-1:0]      addr_s1;
	logic [KIND_W-1:0]     kind_q;
	logic [KEY_WIDTH-1:0]  key_q;
	logic [IDX_W-1:0]      pos_q;
	logic [IDX_W-1:0]      step_q;
	logic                  res_ok_q;
	logic [SLOT_W-1:0]     res_slot_q;

	dht_hash_t          hash;
	logic               accept;
	logic [ENTRY_W-1:0] rdata;
	logic [1:0]         rd_status;
	logic               eval;
	logic               found;
	logic               miss;
	logic               we;
	logic [ENTRY_W-1:0] wdata;
	logic [IDX_W:0]     pos_sum;
	logic [IDX_W-1:0]   pos_next;
	logic               out_free;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	dht_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (s_axis_tdata[KEY_WIDTH-1:0]),
		.res    (hash)
	);

	dht_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_SIZE)
	) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1),
		.wdata (wdata),
		.raddr (pos_q),
		.rdata (rdata)
	);

	// Slots never written since reset read as empty
	assign rd_status = valid_q[addr_s1] ? rdata[KEY_WIDTH +: 2] : SLOT_EMPTY;
	assign eval      = (state_q == S_PROBE) && rv_s1;

	always_comb begin
		found = 1'b0;
		miss  = 1'b0;
		case (kind_q) inside
			KIND_INSERT: found = (rd_status != SLOT_USED);
			KIND_SEARCH, KIND_ERASE: begin
				found = (rd_status == SLOT_USED) && (rdata[KEY_WIDTH-1:0] == key_q);
				miss  = (rd_status == SLOT_EMPTY);
			end
			default: miss = 1'b1;
		endcase
		if (ev_q == IDX_W'(TABLE_SIZE - 1)) begin
			miss = 1'b1;
		end
	end

	assign we    = eval && found && (kind_q != KIND_SEARCH);
	assign wdata = {((kind_q == KIND_INSERT) ? SLOT_USED : SLOT_DELETED), key_q};

	assign pos_sum  = {1'b0, pos_q} + {1'b0, step_q};
	assign pos_next = (pos_sum >= (IDX_W + 1)'(TABLE_SIZE))
		? IDX_W'(pos_sum - (IDX_W + 1)'(TABLE_SIZE)) : pos_sum[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			valid_q       <= '0;
			rv_s1         <= 1'b0;
			ev_q          <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			rv_s1 <= (state_q == S_PROBE);
			// the done state reloads the output register itself
			if (m_axis_tvalid && m_axis_tready && state_q != S_DONE) begin
				m_axis_tvalid <= 1'b0;
			end
			if (we) begin
				valid_q[addr_s1] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					ev_q <= '0;
					if (hash.done) begin
						// an unused operation code skips the walk
						state_q <= (kind_q == KIND_INSERT || kind_q == KIND_SEARCH ||
							kind_q == KIND_ERASE) ? S_PROBE : S_DONE;
					end
				end
				S_PROBE: begin
					if (eval) begin
						ev_q <= ev_q + 1'b1;
						if (found || miss) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						m_axis_tvalid <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= pos_q;
		if (accept) begin
			kind_q <= s_axis_tuser;
			key_q  <= s_axis_tdata[KEY_WIDTH-1:0];
		end
		if (state_q == S_HASH) begin
			pos_q      <= hash.home;
			step_q     <= hash.step;
			res_ok_q   <= 1'b0;
			res_slot_q <= '0;
		end else if (state_q == S_PROBE) begin
			pos_q <= pos_next;
			if (eval && found) begin
				res_ok_q   <= 1'b1;
				res_slot_q <= SLOT_W'(addr_s1);
			end
		end
		if (state_q == S_DONE && out_free) begin
			m_axis_tuser <= res_ok_q;
			m_axis_tdata <= OUT_DATA_W'(res_slot_q);
		end
	end

endmodule

`default_nettype wire
